### design/lbp_3x3_uniform_coder_assert.svh
// ----------------------------------------------------------------------------
// lbp 3x3 uniform coder assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef LBP_3X3_UNIFORM_CODER_ASSERT_SVH
`define LBP_3X3_UNIFORM_CODER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication on clk, disabled in reset
`define LBP3U_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication on clk, disabled in reset
`define LBP3U_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define LBP3U_ASSERT_IMP(lbl, pre, post, msg)
`define LBP3U_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

### design/lbp3u_pkg.sv
// ----------------------------------------------------------------------------
// lbp3u_pkg
// shared constants, types and the uniform label table of the lbp coder
// ----------------------------------------------------------------------------
package lbp3u_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // register field widths and reset values
  localparam int WIDTH_FIELD_W  = 12;
  localparam int HEIGHT_FIELD_W = 13;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int MIN_DIM        = 2;

  // apb port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_UNIFORM_ENABLE = 2'd2;

  // pixel and code widths
  localparam int PIX_W  = 8;
  localparam int LINE_W = 2 * PIX_W;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // uniform label table
  localparam int LUT_SIZE = 256;
  localparam logic [PIX_W-1:0] UNIFORM_OTHER = 8'd58;

  // geometry and restart from the register block
  typedef struct packed {
    logic [COL_W:0] frame_width;
    logic [ROW_W:0] frame_height;
    logic           restart;
  } lbp_geom_t;

  // controls seen by the back end
  typedef struct packed {
    logic restart;
    logic uniform_enable;
  } lbp_back_ctrl_t;

  // one classified item for the back end
  typedef struct packed {
    logic             is_pixel;
    logic             emit;
    logic             up;
    logic             down;
    logic             left;
    logic             right;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] pixel;
  } lbp_cmd_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } lbp_qstat_t;

  // front end position status
  typedef struct packed {
    logic           at_start;
    logic [COL_W:0] pending;
  } lbp_fstat_t;

  typedef logic [PIX_W-1:0] label_lut_t [LUT_SIZE];

  // circular 0/1 transitions of an 8-bit pattern
  function automatic logic [3:0] bit_changes(input logic [PIX_W-1:0] c);
    return 4'($countones(c ^ {c[PIX_W-2:0], c[PIX_W-1]}));
  endfunction

  // uniform patterns get labels in ascending code order, the rest the catch-all
  function automatic label_lut_t build_label_lut();
    label_lut_t       lut;
    logic [PIX_W-1:0] n;
    n = '0;
    for (int v = 0; v < LUT_SIZE; v++) begin
      if (bit_changes(PIX_W'(v)) <= 4'd2) begin
        lut[v] = n;
        n = n + 1'b1;
      end else begin
        lut[v] = UNIFORM_OTHER;
      end
    end
    return lut;
  endfunction

  localparam label_lut_t UNIFORM_LUT = build_label_lut();

endpackage

### design/lbp3u_queue.sv
// ----------------------------------------------------------------------------
// lbp3u_queue
// short command fifo that decouples the front end from the back end
// ----------------------------------------------------------------------------
module lbp3u_queue
  import lbp3u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lbp_cmd_t   push_cmd,
  input  logic       pop,
  output lbp_cmd_t   head_cmd,
  output lbp_qstat_t stat
);

  lbp_cmd_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // status and head
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head_cmd   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### design/lbp3u_front.sv
// ----------------------------------------------------------------------------
// lbp3u_front
// accepts input beats, tracks frame positions and classifies each item
// ----------------------------------------------------------------------------
module lbp3u_front
  import lbp3u_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,   // [7:0] pixel
  input  logic [0:0]       s_tuser,   // [0] func
  input  lbp_geom_t        geom,
  input  lbp_qstat_t       qstat,
  output logic             push,
  output lbp_cmd_t         cmd,
  output lbp_fstat_t       fstat
);

  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [COL_W:0]   pending;

  logic accept;
  logic is_flush;
  logic at_start;
  logic in_col_last;
  logic in_row_last;
  logic out_right;
  logic out_down;
  logic pix_emit;
  logic flush_emit;
  logic emit;

  assign s_tready = !qstat.full;

  // classify the item at the input
  always_comb begin
    accept      = s_tvalid && s_tready;
    is_flush    = s_tuser[0];
    at_start    = (in_col == '0) && (in_row == '0);
    in_col_last = (({1'b0, in_col} + 1'b1) == geom.frame_width);
    in_row_last = (({1'b0, in_row} + 1'b1) == geom.frame_height);
    out_right   = (({1'b0, out_col} + 1'b1) < geom.frame_width);
    out_down    = (({1'b0, out_row} + 1'b1) < geom.frame_height);
    pix_emit    = (pending > geom.frame_width);
    flush_emit  = at_start && (pending != '0);
    emit        = is_flush ? flush_emit : pix_emit;
    push        = accept && (!is_flush || flush_emit);
  end

  // command for the back end
  always_comb begin
    cmd.is_pixel = !is_flush;
    cmd.emit     = emit;
    cmd.up       = (out_row != '0);
    cmd.down     = out_down;
    cmd.left     = (out_col != '0);
    cmd.right    = out_right;
    cmd.addr     = is_flush ? (out_right ? out_col + 1'b1 : '0) : in_col;
    cmd.pixel    = s_tdata;
  end

  assign fstat.at_start = at_start;
  assign fstat.pending  = pending;

  // input and output positions, pending count
  always_ff @(posedge clk) begin
    if (rst || geom.restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else if (accept) begin
      if (!is_flush) begin
        if (in_col_last) begin
          in_col <= '0;
          in_row <= in_row_last ? '0 : in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (!pix_emit) begin
          pending <= pending + 1'b1;
        end
      end else if (flush_emit) begin
        pending <= pending - 1'b1;
      end
      if (emit) begin
        if (!out_right) begin
          out_col <= '0;
          out_row <= out_down ? out_row + 1'b1 : '0;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

endmodule

### design/lbp3u_back.sv
// ----------------------------------------------------------------------------
// lbp3u_back
// line store, 3x3 window, neighbor compare, uniform mapping and output beat
// ----------------------------------------------------------------------------
module lbp3u_back
  import lbp3u_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lbp_back_ctrl_t   ctrl,
  input  lbp_cmd_t         head_cmd,
  input  lbp_qstat_t       qstat,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [PIX_W-1:0] m_tdata,   // [7:0] code
  output logic             m_tlast
);

  // both previous rows in one entry: upper in the high byte, middle in the low
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_data;
  logic              bypass_hit;
  logic [LINE_W-1:0] bypass_data;

  logic              adv;
  logic              s1_valid;
  lbp_cmd_t          s1_cmd;
  logic [LINE_W-1:0] line_eff;
  logic [LINE_W-1:0] wr_data;
  logic [PIX_W-1:0]  incoming [3];

  logic [PIX_W-1:0]  win [9];
  logic              s2_valid;
  logic              s2_up;
  logic              s2_down;
  logic              s2_left;
  logic              s2_right;

  logic              s3_valid;
  logic [PIX_W-1:0]  s3_code;
  logic              s3_last;
  logic [PIX_W-1:0]  raw_code;
  logic [PIX_W-1:0]  ctr;

  // whole pipeline moves when the output register is free or being taken
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !qstat.empty;

  // line data with forwarding of the write that raced this read
  always_comb begin
    line_eff    = bypass_hit ? bypass_data : rd_data;
    wr_data     = {line_eff[PIX_W-1:0], s1_cmd.pixel};
    incoming[0] = line_eff[LINE_W-1:PIX_W];
    incoming[1] = line_eff[PIX_W-1:0];
    incoming[2] = s1_cmd.is_pixel ? s1_cmd.pixel : '0;
  end

  // line store: read on pop, row shift write as the item leaves stage one
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= line_mem[head_cmd.addr];
    end
    if (adv && s1_valid && s1_cmd.is_pixel) begin
      line_mem[s1_cmd.addr] <= wr_data;
    end
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_hit <= 1'b0;
    end else if (adv) begin
      bypass_hit <= pop && s1_valid && s1_cmd.is_pixel && (head_cmd.addr == s1_cmd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bypass_data <= wr_data;
    end
  end

  // stage one: command waiting for its line data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd <= head_cmd;
    end
  end

  // stage two: window shift, one column per item
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
        win[r*3 + 2] <= incoming[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_up    <= s1_cmd.up;
      s2_down  <= s1_cmd.down;
      s2_left  <= s1_cmd.left;
      s2_right <= s1_cmd.right;
    end
  end

  // neighbor compare against the center, masked at the frame border
  always_comb begin
    ctr         = win[4];
    raw_code[7] = s2_up && (win[1] > ctr);
    raw_code[6] = s2_up && s2_right && (win[2] > ctr);
    raw_code[5] = s2_right && (win[5] > ctr);
    raw_code[4] = s2_down && s2_right && (win[8] > ctr);
    raw_code[3] = s2_down && (win[7] > ctr);
    raw_code[2] = s2_down && s2_left && (win[6] > ctr);
    raw_code[1] = s2_left && (win[3] > ctr);
    raw_code[0] = s2_up && s2_left && (win[0] > ctr);
  end

  // stage three: raw code
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_code <= raw_code;
      s3_last <= !s2_down && !s2_right;
    end
  end

  // output register with optional uniform mapping
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= ctrl.uniform_enable ? UNIFORM_LUT[s3_code] : s3_code;
      m_tlast <= s3_last;
    end
  end

endmodule

### design/lbp_3x3_uniform_coder.sv
// ----------------------------------------------------------------------------
// lbp_3x3_uniform_coder
// streaming 3x3 local binary pattern coder with optional uniform labels
// ----------------------------------------------------------------------------
// Gray pixels enter on the slave stream in raster order, one per beat, with
// s_tuser[0] low; a beat with s_tuser[0] high is a flush that carries no pixel.
// Each pixel's 8-bit code leaves on the master stream frame_width+1 pixel
// beats after its own; flush beats after a complete frame push out the tail,
// and m_tlast marks the code of the bottom-right pixel. Flushes with nothing
// to release are dropped.
// Throughput is one beat per clock on both sides while m_tready stays high.
// A code released by an input beat reaches m_tvalid through the queue, line
// store read, window shift, compare, table and output register.
// The geometry and mode registers sit on the apb port (0x0 width, 0x4 height,
// 0x8 uniform mode); a geometry write restarts the frame.
// Reset sets 640x480 raw mode and clears positions and window; the line
// store is not cleared. When m_tready is low the back end holds, a 4-entry
// command queue takes further beats, and s_tready drops once it is full.
// ----------------------------------------------------------------------------
`include "lbp_3x3_uniform_coder_assert.svh"

module lbp_3x3_uniform_coder
  import lbp3u_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
  input  logic [0:0]            s_tuser,   // [0] func
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_W-1:0]      m_tdata,   // [7:0] code
  output logic                  m_tlast,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [COL_W:0]  frame_width;
  logic [ROW_W:0]  frame_height;
  logic            uniform_enable;

  logic            wr_en;
  logic [1:0]      reg_idx;
  logic [31:0]     fw_raw;
  logic [31:0]     fh_raw;
  logic [31:0]     fw_clamped;
  logic [31:0]     fh_clamped;

  lbp_geom_t       geom;
  lbp_back_ctrl_t  back_ctrl;
  lbp_qstat_t      q_stat;
  lbp_fstat_t      fstat;
  lbp_cmd_t        q_push_cmd;
  lbp_cmd_t        q_head_cmd;
  logic            q_push;
  logic            q_pop;

  logic            flush_mid_frame;
  logic            pending_in_range;
  logic            restart_cleared;

  // apb decode
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // saturate geometry writes into the supported range
  always_comb begin
    fw_raw     = {{(32-WIDTH_FIELD_W){1'b0}}, pwdata[WIDTH_FIELD_W-1:0]};
    fh_raw     = {{(32-HEIGHT_FIELD_W){1'b0}}, pwdata[HEIGHT_FIELD_W-1:0]};
    fw_clamped = (fw_raw < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
                 (fw_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw_raw;
    fh_clamped = (fh_raw < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
                 (fh_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh_raw;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= (COL_W+1)'(WIDTH_RESET);
      frame_height   <= (ROW_W+1)'(HEIGHT_RESET);
      uniform_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:    frame_width    <= fw_clamped[COL_W:0];
        REG_FRAME_HEIGHT:   frame_height   <= fh_clamped[ROW_W:0];
        REG_UNIFORM_ENABLE: uniform_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:    prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT:   prdata = APB_DATA_W'(frame_height);
      REG_UNIFORM_ENABLE: prdata = APB_DATA_W'(uniform_enable);
      default:            prdata = '0;
    endcase
  end

  // geometry write restarts the frame in the same cycle
  always_comb begin
    geom.frame_width        = frame_width;
    geom.frame_height       = frame_height;
    geom.restart            = wr_en && ((reg_idx == REG_FRAME_WIDTH) ||
                                        (reg_idx == REG_FRAME_HEIGHT));
    back_ctrl.restart        = geom.restart;
    back_ctrl.uniform_enable = uniform_enable;
  end

  lbp3u_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .geom     (geom),
    .qstat    (q_stat),
    .push     (q_push),
    .cmd      (q_push_cmd),
    .fstat    (fstat)
  );

  lbp3u_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .stat     (q_stat)
  );

  lbp3u_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (back_ctrl),
    .head_cmd (q_head_cmd),
    .qstat    (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // assertion terms
  assign flush_mid_frame  = s_tvalid && s_tready && s_tuser[0] && !fstat.at_start;
  assign pending_in_range = ({1'b0, fstat.pending} <= ({1'b0, frame_width} + 1'b1));
  assign restart_cleared  = fstat.at_start && (fstat.pending == '0);

  // assertions
  `LBP3U_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full, "command queue overflow")
  `LBP3U_ASSERT_IMP(a_flush_drop, flush_mid_frame, !q_push, "flush inside a frame was queued")
  `LBP3U_ASSERT_IMP(a_pending_bound, 1'b1, pending_in_range, "pending count above width plus one")
  `LBP3U_ASSERT_NXT(a_restart_clears, geom.restart, restart_cleared, "restart left positions set")

endmodule

### bench/lbp_3x3_uniform_coder_tb.sv
// ----------------------------------------------------------------------------
// lbp_3x3_uniform_coder_tb
// self-checking bench for the streaming 3x3 lbp coder
// ----------------------------------------------------------------------------
// Pixel and flush beats go in on the slave stream while a scoreboard runs its
// own copy of the line stores, window and frame positions to predict every
// code, label and end-of-frame flag. Codes on the master stream are checked in
// order against the scoreboard. A short directed run covers extreme pixels,
// dropped flushes, the unused register address and a frame that runs straight
// into the next one. Random phases then vary geometry and mode over the apb
// port and send whole, cut and flushed frames with random idling on both
// sides. A receiver hold-off backs up the block, and three runs use the largest
// width or height.
// ----------------------------------------------------------------------------
module lbp_3x3_uniform_coder_tb;
  import lbp3u_pkg::*;

  // address with no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  // item kinds carried in s_tuser
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // pixel content styles
  localparam int STYLE_NOISE    = 0;
  localparam int STYLE_EXTREMES = 1;
  localparam int STYLE_FLAT     = 2;

  // geometry limits and reset values of the block
  localparam int unsigned LIMIT_W      = 2048;
  localparam int unsigned LIMIT_H      = 4096;
  localparam int unsigned POR_WIDTH    = 640;
  localparam int unsigned POR_HEIGHT   = 480;
  localparam logic [7:0]  NON_UNIFORM  = 8'd58;

  localparam int QUIET_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int ITEM_TARGET  = 1150;
  localparam int HOLD_CYCLES  = 150;

  // predicts codes from accepted beats and checks codes leaving the block
  class lbp_code_scoreboard;
    int unsigned frame_w;
    int unsigned frame_h;
    bit          uniform_on;
    bit [7:0]    upper_line [LIMIT_W];
    bit [7:0]    middle_line [LIMIT_W];
    bit [7:0]    win [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    bit [7:0]    label_lut [256];
    bit [8:0]    expected_q [$];  // {last, code}
    int unsigned mismatches;

    function new();
      int unsigned n;
      n = 0;
      // uniform patterns numbered in ascending code order
      for (int v = 0; v < 256; v++) begin
        if (transitions(8'(v)) <= 2) begin
          label_lut[v] = 8'(n);
          n++;
        end else begin
          label_lut[v] = NON_UNIFORM;
        end
      end
      frame_w    = POR_WIDTH;
      frame_h    = POR_HEIGHT;
      uniform_on = 1'b0;
      mismatches = 0;
      restart();
    endfunction

    // circular 0/1 changes around the ring of eight bits
    function int unsigned transitions(bit [7:0] c);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 8; i++)
        if (c[i] != c[(i + 1) % 8]) n++;
      return n;
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      foreach (win[r, c]) win[r][c] = '0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < 2) ? 2 : ((v > hi) ? hi : v);
    endfunction

    function void apply_reg_write(bit [1:0] idx, bit [31:0] value);
      case (idx)
        REG_FRAME_WIDTH: begin
          frame_w = clamp_dim(32'(value[11:0]), LIMIT_W);
          restart();
        end
        REG_FRAME_HEIGHT: begin
          frame_h = clamp_dim(32'(value[12:0]), LIMIT_H);
          restart();
        end
        REG_UNIFORM_ENABLE: uniform_on = value[0];
        default: ;
      endcase
    endfunction

    // pixels taken in but not yet coded, with frame wrap
    function int unsigned pending();
      int unsigned a, b;
      a = in_row * frame_w + in_col;
      b = out_row * frame_w + out_col;
      return (a >= b) ? a - b : a + frame_w * frame_h - b;
    endfunction

    function void step_pos(inout int unsigned col, inout int unsigned row);
      col++;
      if (col >= frame_w) begin
        col = 0;
        row++;
        if (row >= frame_h) row = 0;
      end
    endfunction

    function void shift_window(bit [7:0] top, bit [7:0] mid, bit [7:0] bot);
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
    endfunction

    // code of the oldest pending pixel, neighbors off the frame masked
    function void emit_code();
      bit [7:0] ctr, code;
      bit       up, down, left, right;
      ctr   = win[1][1];
      up    = out_row > 0;
      down  = out_row + 1 < frame_h;
      left  = out_col > 0;
      right = out_col + 1 < frame_w;
      code  = '0;
      code[7] = up && win[0][1] > ctr;
      code[6] = up && right && win[0][2] > ctr;
      code[5] = right && win[1][2] > ctr;
      code[4] = down && right && win[2][2] > ctr;
      code[3] = down && win[2][1] > ctr;
      code[2] = down && left && win[2][0] > ctr;
      code[1] = left && win[1][0] > ctr;
      code[0] = up && left && win[0][0] > ctr;
      if (uniform_on) code = label_lut[code];
      expected_q.push_back({!down && !right, code});
      step_pos(out_col, out_row);
    endfunction

    // returns 1 when the beat releases a code
    function bit note_beat(bit func, bit [7:0] pix);
      int unsigned col, p;
      if (func == FUNC_PIXEL) begin
        col = in_col;
        shift_window(upper_line[col], middle_line[col], pix);
        upper_line[col]  = middle_line[col];
        middle_line[col] = pix;
        p = pending() + 1;
        step_pos(in_col, in_row);
        if (p >= frame_w + 2) begin
          emit_code();
          return 1'b1;
        end
        return 1'b0;
      end
      // flush only counts once the whole frame is in
      if (in_col == 0 && in_row == 0 && pending() > 0) begin
        col = (out_col + 1) % frame_w;
        shift_window(upper_line[col], middle_line[col], 8'd0);
        emit_code();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    task report(string what);
      if (mismatches < 100) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_code(logic [7:0] code, logic last);
      bit [8:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("code %02h last %b with nothing expected", code, last));
        return;
      end
      want = expected_q.pop_front();
      if (code !== want[7:0])
        report($sformatf("code %02h, expected %02h", code, want[7:0]));
      if (last !== want[8])
        report($sformatf("last %b, expected %b (code %02h)", last, want[8], want[7:0]));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;   // [7:0] pixel
  logic [0:0]            s_tuser;   // [0] func
  logic                  m_tvalid;
  logic                  m_tready;
  logic [PIX_W-1:0]      m_tdata;   // [7:0] code
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lbp_code_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned work_items;
  int unsigned hold_seq;
  int unsigned hold_len;
  int unsigned stall_run;
  logic [7:0]  base_level;

  lbp_3x3_uniform_coder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int unsigned seen_seq;
    int unsigned hold_left;
    seen_seq  = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // check every code beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_code(m_tdata, m_tlast);
  end

  // watchdog on cycles with no beat and no register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      stall_run <= 0;
    else
      stall_run <= stall_run + 1;
    if (stall_run >= STALL_LIMIT) begin
      $display("lbp_3x3_uniform_coder_tb failed");
      $finish;
    end
  end

  // apb write: setup then access cycle
  task write_reg(bit [1:0] idx, bit [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.apply_reg_write(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one input beat, with random idle cycles ahead of it
  task send_beat(logic func, logic [7:0] pix);
    bit produced;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    produced = sb.note_beat(func, pix);
    if (func == FUNC_PIXEL || produced) work_items++;
  endtask

  // stop sending, let all codes arrive and the pipeline settle
  task wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] next_pixel(int style);
    case (style)
      STYLE_NOISE: return 8'($urandom);
      STYLE_EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       return 8'd0;
          1:       return 8'd1;
          2:       return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: return 8'(base_level + 8'($urandom_range(0, 2)));
    endcase
  endfunction

  // one frame of pixels with stray flushes, sometimes cut short, then a tail of flushes or none
  task push_frame();
    int unsigned w, h, n, tail;
    int          style;
    w = sb.frame_w;
    h = sb.frame_h;
    n = w * h;
    if ($urandom_range(99) < 20) n = $urandom_range(1, n - 1);
    style      = $urandom_range(0, 2);
    base_level = 8'($urandom_range(0, 253));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send_beat(FUNC_FLUSH, 8'($urandom));
      send_beat(FUNC_PIXEL, next_pixel(style));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: tail = w + 1 + $urandom_range(0, 2);
      5, 6, 7:       tail = 0;
      default:       tail = $urandom_range(1, w);
    endcase
    repeat (tail) send_beat(FUNC_FLUSH, 8'($urandom));
  endtask

  function automatic int unsigned pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(0, 2);
    if (r < 85) return $urandom_range(3, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int unsigned pick_height();
    if ($urandom_range(99) < 8) return $urandom_range(0, 2);
    return $urandom_range(2, 6);
  endfunction

  // new settings with junk in unused bits, then a few frames
  task random_phase();
    if ($urandom_range(99) < 80)
      write_reg(REG_FRAME_WIDTH, ($urandom & 32'hFFFF_F000) | pick_width());
    if ($urandom_range(99) < 80)
      write_reg(REG_FRAME_HEIGHT, ($urandom & 32'hFFFF_E000) | pick_height());
    write_reg(REG_UNIFORM_ENABLE, ($urandom & 32'hFFFF_FFFE) | $urandom_range(0, 1));
    repeat ($urandom_range(1, 3)) push_frame();
    wait_quiet();
  endtask

  initial begin
    bit [7:0] cross_pix [9];
    bit [7:0] tiny_pix [8];
    int unsigned stop_at;

    cross_pix     = '{8'd255, 8'd0, 8'd255,
                      8'd0, 8'd128, 8'd0,
                      8'd255, 8'd0, 8'd255};
    tiny_pix      = '{8'd7, 8'd7, 8'd8, 8'd6,
                      8'd0, 8'd255, 8'd255, 8'd0};
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 13;
    recv_idle_pct = 86;
    work_items    = 0;
    hold_seq      = 0;
    hold_len      = 0;
    base_level    = '0;
    sb = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x3 raw frame: dropped flushes before, inside and after the frame
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(REG_FRAME_WIDTH, 32'd3);
    write_reg(REG_FRAME_HEIGHT, 32'd3);
    write_reg(REG_UNIFORM_ENABLE, 32'd0);
    send_beat(FUNC_FLUSH, 8'hA5);
    for (int i = 0; i < 9; i++) begin
      send_beat(FUNC_PIXEL, cross_pix[i]);
      if (i == 3) send_beat(FUNC_FLUSH, 8'hFF);
    end
    repeat (5) send_beat(FUNC_FLUSH, 8'h00);
    wait_quiet();

    // smallest geometry through saturation, labels on, frame into next frame
    write_reg(REG_FRAME_WIDTH, 32'h0000_F001);
    write_reg(REG_FRAME_HEIGHT, 32'h0000_0000);
    write_reg(REG_UNIFORM_ENABLE, 32'd1);
    for (int i = 0; i < 8; i++) send_beat(FUNC_PIXEL, tiny_pix[i]);
    repeat (3) send_beat(FUNC_FLUSH, 8'h5A);
    wait_quiet();

    // random phases under three idling patterns
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (stage == 2) begin
        // receiver holds off while pixels keep coming, so the input stalls
        write_reg(REG_FRAME_WIDTH, 32'd8);
        write_reg(REG_FRAME_HEIGHT, 32'd4);
        write_reg(REG_UNIFORM_ENABLE, $urandom_range(0, 1));
        hold_len = HOLD_CYCLES;
        hold_seq++;
        repeat (64) send_beat(FUNC_PIXEL, 8'($urandom));
        repeat (9) send_beat(FUNC_FLUSH, 8'($urandom));
        wait_quiet();
      end
      stop_at = work_items + ITEM_TARGET / 3;
      while (work_items < stop_at) random_phase();
    end

    // widest line, saturated from the top of the field, too short for any code
    write_reg(REG_FRAME_WIDTH, 32'h0000_0FFF);
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    write_reg(REG_UNIFORM_ENABLE, $urandom_range(0, 1));
    base_level = 8'($urandom_range(0, 253));
    repeat (100) send_beat(FUNC_PIXEL, next_pixel($urandom_range(0, 2)));
    wait_quiet();

    // exact widest width, then tallest frame, saturated, partly sent
    write_reg(REG_FRAME_WIDTH, LIMIT_W);
    write_reg(REG_FRAME_WIDTH, 32'd2);
    write_reg(REG_FRAME_HEIGHT, 32'h0000_1FFF);
    repeat (200) send_beat(FUNC_PIXEL, 8'($urandom));
    wait_quiet();
    write_reg(REG_FRAME_HEIGHT, LIMIT_H);
    repeat (40) send_beat(FUNC_PIXEL, 8'($urandom));
    wait_quiet();

    // closing 2x2 frame flushed out
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    repeat (4) send_beat(FUNC_PIXEL, 8'($urandom));
    repeat (3) send_beat(FUNC_FLUSH, 8'($urandom));
    wait_quiet();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("lbp_3x3_uniform_coder_tb passed");
    else
      $display("lbp_3x3_uniform_coder_tb failed");
    $finish;
  end

endmodule

### lbp_3x3_uniform_coder.f
+incdir+design
design/lbp3u_pkg.sv
design/lbp3u_queue.sv
design/lbp3u_front.sv
design/lbp3u_back.sv
design/lbp_3x3_uniform_coder.sv
bench/lbp_3x3_uniform_coder_tb.sv
